[sv/fprx_pkg.sv]
package fprx_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 10;
  localparam int unsigned PAYLOAD_DEPTH   = 8;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  localparam int unsigned START_RESET   = 2;
  localparam int unsigned TIMEOUT_RESET = 1000;

  typedef enum logic [1:0] {
    PhReady     = 2'd0,
    PhReceiving = 2'd1,
    PhHolding   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    OpByte    = 2'd0,
    OpTick    = 2'd1,
    OpRelease = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    StNone     = 2'd0,
    StComplete = 2'd1,
    StOverflow = 2'd2,
    StTimeout  = 2'd3
  } status_e;

  typedef enum logic {
    CfgStartByte    = 1'b0,
    CfgTimeoutTicks = 1'b1
  } cfg_idx_e;

endpackage

[sv/framed_packet_receiver_xor_check.sv]
// channel | direction | handshake          | payload
// --------+-----------+--------------------+---------------------------------------------
// in      | input     | in_valid_i/in_stall_o   | opcode_i, rx_byte_i
// out     | output    | out_valid_o/out_stall_i | status_o, packet_pending_o, command_o,
//         |           |                    | length_o, payload_o, checksum_ok_o
// cfg     | input     | cfg_we_i           | cfg_idx_i, cfg_wdata_i (no read-back)
//
// one request per cycle sustained while the result is not stalled; each request passes through
// the input register, then the frame state update and the result register
// every request gives exactly one result
// reset (rst_ni low, asynchronous) empties both stages and returns the phase to ready
// a stalled result holds the whole pipe; the input register still takes one request
// while the result register is full and waiting
module framed_packet_receiver_xor_check import fprx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        packet_pending_o,
  output logic [7:0]  command_o,
  output logic [7:0]  length_o,
  output logic [63:0] payload_o,
  output logic        checksum_ok_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  // configuration
  logic [7:0]  start_q;
  logic [15:0] timeout_q;

  // input register
  logic        s1_valid_q;
  logic [1:0]  s1_opcode_q;
  logic [7:0]  s1_byte_q;

  // frame state
  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        rxck_q, rxck_d;
  logic [7:0]        xor_q, xor_d;
  logic [15:0]       tick_q, tick_d;
  logic [7:0]        store_q [PAYLOAD_DEPTH];
  logic              store_we;
  logic [IDX_W-1:0]  store_idx;

  // result register
  logic        out_valid_q;
  logic [1:0]  status_q, status_d;
  logic        pend_q, pend_d;
  logic [7:0]  cmd_out_q, cmd_out_d;
  logic [7:0]  len_out_q, len_out_d;
  logic [63:0] pay_out_q, pay_out_d;
  logic        ck_out_q, ck_out_d;

  logic advance;
  logic accept;
  logic work;

  // the result register frees up when empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign work       = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= 8'(START_RESET);
      timeout_q <= 16'(TIMEOUT_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartByte:    start_q   <= cfg_wdata_i[7:0];
        CfgTimeoutTicks: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_opcode_q <= opcode_i;
      s1_byte_q   <= rx_byte_i;
    end
  end

  // frame state machine: one request per pass
  always_comb begin
    logic [7:0]       idx;
    logic [CNT_W:0]   cnt_inc;
    logic [7:0]       n_bytes;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    rxck_d    = rxck_q;
    xor_d     = xor_q;
    tick_d    = tick_q;
    status_d  = StNone;
    store_we  = 1'b0;
    idx       = 8'(cnt_q) - 8'd2;
    store_idx = idx[IDX_W-1:0];
    cnt_inc   = {1'b0, cnt_q} + 1'b1;

    case (s1_opcode_q)
      OpByte: begin
        case (phase_q)
          PhReady: begin
            if (s1_byte_q == start_q) begin
              phase_d = PhReceiving;
              cnt_d   = '0;
              tick_d  = '0;
              xor_d   = start_q;
            end
          end
          PhReceiving: begin
            if (cnt_q == CNT_W'(0)) begin
              cmd_d = s1_byte_q;
              xor_d = xor_q ^ s1_byte_q;
            end else if (cnt_q == CNT_W'(1)) begin
              len_d = s1_byte_q;
              xor_d = xor_q ^ s1_byte_q;
            end else if (idx == len_q) begin
              // checksum byte closes the frame
              rxck_d   = s1_byte_q;
              phase_d  = PhHolding;
              status_d = StComplete;
            end else begin
              // bytes past the store still count in the xor
              store_we = (idx < 8'(PAYLOAD_DEPTH));
              xor_d    = xor_q ^ s1_byte_q;
            end
            if (cnt_inc > (CNT_W+1)'(MAX_FRAME_BYTES)) begin
              phase_d  = PhReady;
              cnt_d    = '0;
              status_d = StOverflow;
            end else begin
              cnt_d = cnt_inc[CNT_W-1:0];
            end
          end
          default: ;
        endcase
      end
      OpTick: begin
        if (phase_q == PhReceiving) begin
          if (tick_q != 16'hffff) begin
            tick_d = tick_q + 16'd1;
          end
          if (tick_d >= timeout_q) begin
            phase_d  = PhReady;
            cnt_d    = '0;
            tick_d   = '0;
            status_d = StTimeout;
          end
        end
      end
      OpRelease: begin
        phase_d = PhReady;
        cnt_d   = '0;
      end
      default: ;
    endcase

    // result fields reflect the state after this request
    pend_d    = (phase_d == PhHolding);
    cmd_out_d = pend_d ? cmd_d : 8'd0;
    len_out_d = pend_d ? len_d : 8'd0;
    ck_out_d  = pend_d && (xor_d == rxck_d);
    n_bytes   = (len_d > 8'(PAYLOAD_DEPTH)) ? 8'(PAYLOAD_DEPTH) : len_d;
    pay_out_d = '0;
    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
      if (pend_d && (8'(i) < n_bytes)) begin
        pay_out_d[8*i +: 8] = store_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhReady;
    end else if (work) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cmd_q  <= '0;
      len_q  <= '0;
      rxck_q <= '0;
      xor_q  <= '0;
      tick_q <= '0;
    end else if (work) begin
      cnt_q  <= cnt_d;
      cmd_q  <= cmd_d;
      len_q  <= len_d;
      rxck_q <= rxck_d;
      xor_q  <= xor_d;
      tick_q <= tick_d;
    end
  end

  // payload store: only ever read within the held length
  always_ff @(posedge clk_i) begin
    if (work && store_we) begin
      store_q[store_idx] <= s1_byte_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      status_q  <= status_d;
      pend_q    <= pend_d;
      cmd_out_q <= cmd_out_d;
      len_out_q <= len_out_d;
      pay_out_q <= pay_out_d;
      ck_out_q  <= ck_out_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign packet_pending_o = pend_q;
  assign command_o        = cmd_out_q;
  assign length_o         = len_out_q;
  assign payload_o        = pay_out_q;
  assign checksum_ok_o    = ck_out_q;

endmodule

[sv/fprx_checker.sv]
module fprx_checker import fprx_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic        packet_pending_o,
  input logic [7:0]  command_o,
  input logic [7:0]  length_o,
  input logic [63:0] payload_o,
  input logic        checksum_ok_o
);

  // nothing held means blank frame fields
  a_blank_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !packet_pending_o |->
      command_o == 8'd0 && length_o == 8'd0 && payload_o == 64'd0 && !checksum_ok_o)
    else $error("frame fields set with no frame held");

  // a completed frame is always held
  a_complete_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StComplete |-> packet_pending_o)
    else $error("complete status without held frame");

  // discards never leave a frame held
  a_discard_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StOverflow || status_o == StTimeout) |-> !packet_pending_o)
    else $error("discard status with held frame");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(payload_o))
    else $error("stalled result changed");

endmodule

bind framed_packet_receiver_xor_check fprx_checker u_fprx_checker (.*);
